// File: sv/ptt_pkg.sv
// ============================================================================
// ptt_pkg - shared types and constants for the periodic tick timer table
// Command and result structs, the token that walks the cell chain, and the
// kind and event codes.
// ============================================================================
`default_nettype none

package ptt_pkg;

	// table geometry
	localparam int NUM_SLOTS   = 16;
	localparam int PERIOD_BITS = 16;
	localparam int SLOT_BITS   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	// width used to compare the 4-bit slot field against a cell index
	localparam int CMP_BITS    = (SLOT_BITS > 4) ? SLOT_BITS : 4;

	// command kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_REG   = 2'd1;
	localparam logic [1:0] KIND_UNREG = 2'd2;
	localparam logic [1:0] KIND_CLEAR = 2'd3;

	// result events
	localparam logic [2:0] EV_FIRED       = 3'd0;
	localparam logic [2:0] EV_REGISTERED  = 3'd1;
	localparam logic [2:0] EV_REJECTED    = 3'd2;
	localparam logic [2:0] EV_UNREGISTERED = 3'd3;
	localparam logic [2:0] EV_UNREG_EMPTY = 3'd4;

	// input transfer
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] period;
		logic [3:0]  slot;
	} cmd_t;

	// output transfer
	typedef struct packed {
		logic [2:0] event_res;
		logic [3:0] slot_index;
		logic       last_of_run;
	} res_t;

	// command token handed from cell to cell
	typedef struct packed {
		logic                   active;
		logic [1:0]             kind;
		logic [PERIOD_BITS-1:0] period;
		logic [3:0]             slot;
		logic [SLOT_BITS-1:0]   idx;
		logic                   found;
		logic [SLOT_BITS-1:0]   found_idx;
	} token_t;

	// firing report of one cell
	typedef struct packed {
		logic                 fire;
		logic [SLOT_BITS-1:0] idx;
	} cell_fire_t;

endpackage

`default_nettype wire

// File: sv/ptt_cell.sv
// ============================================================================
// ptt_cell - one timer slot of the chain
// Holds valid, period and count of one slot, acts on the command token as it
// passes and hands the token on to the next cell through its token register.
// ============================================================================
`default_nettype none

module ptt_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               clear,
	input  wire ptt_pkg::token_t    tok_in,
	output ptt_pkg::token_t         tok_out,
	output ptt_pkg::cell_fire_t     fire
);

	logic                            valid_q;
	logic [ptt_pkg::PERIOD_BITS-1:0] period_q;
	logic [ptt_pkg::PERIOD_BITS-1:0] count_q;
	ptt_pkg::token_t                 tok_q;
	ptt_pkg::cell_fire_t             fire_q;

	ptt_pkg::token_t                 tok_d;
	logic                            take;
	logic                            drop;
	logic                            step;
	logic                            fire_now;
	logic                            match_here;

	// decide what this cell does with the passing token
	always_comb begin
		tok_d      = tok_in;
		tok_d.idx  = ptt_pkg::SLOT_BITS'(tok_in.idx + 1'b1);
		take       = 1'b0;
		drop       = 1'b0;
		step       = 1'b0;
		fire_now   = 1'b0;
		match_here = (ptt_pkg::CMP_BITS'(tok_in.slot) == ptt_pkg::CMP_BITS'(tok_in.idx));
		if (tok_in.active) begin
			unique case (tok_in.kind)
				ptt_pkg::KIND_TICK: begin
					if (valid_q) begin
						step     = 1'b1;
						fire_now = (count_q == period_q);
					end
				end
				ptt_pkg::KIND_REG: begin
					if (!tok_in.found && !valid_q && (tok_in.period != '0)) begin
						take            = 1'b1;
						tok_d.found     = 1'b1;
						tok_d.found_idx = tok_in.idx;
					end
				end
				ptt_pkg::KIND_UNREG: begin
					if (match_here && valid_q) begin
						drop        = 1'b1;
						tok_d.found = 1'b1;
					end
				end
				ptt_pkg::KIND_CLEAR: begin
				end
			endcase
		end
	end

	// valid mark, token and firing report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
			fire_q  <= '0;
		end else begin
			if (clear || drop)
				valid_q <= 1'b0;
			else if (take)
				valid_q <= 1'b1;
			tok_q       <= tok_d;
			fire_q.fire <= fire_now;
			fire_q.idx  <= tok_in.idx;
		end
	end

	// period and count
	always_ff @(posedge clk) begin
		if (take) begin
			period_q <= tok_in.period;
			count_q  <= '0;
		end else if (step) begin
			if (fire_now)
				count_q <= '0;
			else
				count_q <= ptt_pkg::PERIOD_BITS'(count_q + 1'b1);
		end
	end

	assign tok_out = tok_q;
	assign fire    = fire_q;

endmodule

`default_nettype wire

// File: sv/periodic_tick_timer_table.sv
// ============================================================================
// periodic_tick_timer_table - table of periodic timers in a chain of cells
// Commands enter through start/busy; results leave on a one-cycle strobe.
// ============================================================================
// Usage:
//   A command transfer happens at a clock edge with start high and busy low.
//   Kinds: tick, register timer, unregister slot, clear all slots.
//   Clear takes effect at its transfer edge, gives no result and leaves busy
//   low. Every other command raises busy and walks a token through the row
//   of NUM_SLOTS cells, one cell per cycle; each cell acts on its own slot.
//   Results appear on result with strobe high for exactly one cycle and are
//   taken at the end of that cycle; the receiver cannot stall them.
//   Register and unregister give one result, registered after the token
//   leaves the last cell. A tick gives one result per firing slot, in
//   ascending slot order, at most one per cycle, the last one marked by
//   last_of_run; the final result is registered after the token leaves
//   the last cell. busy falls with the final result, so the length of a
//   command is set by the token walk through the cell chain.
//   Reset empties the table and drops any command in flight.
// ============================================================================
`default_nettype none

module periodic_tick_timer_table (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire ptt_pkg::cmd_t cmd,
	output logic               strobe,
	output ptt_pkg::res_t      result
);

	ptt_pkg::token_t     tok_s0;
	ptt_pkg::token_t     tok_chain [ptt_pkg::NUM_SLOTS+1];
	ptt_pkg::cell_fire_t fires [ptt_pkg::NUM_SLOTS];
	ptt_pkg::token_t     done_q;

	logic                          busy_q;
	logic                          pend_valid_q;
	logic [ptt_pkg::SLOT_BITS-1:0] pend_idx_q;
	logic                          strobe_q;
	ptt_pkg::res_t                 result_q;

	logic                          accept;
	logic                          clear_all;
	logic                          fire_any;
	logic [ptt_pkg::SLOT_BITS-1:0] fire_idx;
	logic                          busy_d;
	logic                          pend_valid_d;
	logic [ptt_pkg::SLOT_BITS-1:0] pend_idx_d;
	logic                          strobe_d;
	ptt_pkg::res_t                 result_d;
	ptt_pkg::token_t               launch_d;

	assign accept    = start && !busy_q;
	assign clear_all = accept && (cmd.kind == ptt_pkg::KIND_CLEAR);

	// token injected into the first cell
	always_comb begin
		launch_d           = '0;
		launch_d.active    = accept && (cmd.kind != ptt_pkg::KIND_CLEAR);
		launch_d.kind      = cmd.kind;
		launch_d.period    = ptt_pkg::PERIOD_BITS'(cmd.period);
		launch_d.slot      = cmd.slot;
	end

	assign tok_chain[0] = tok_s0;

	// row of slot cells
	for (genvar i = 0; i < ptt_pkg::NUM_SLOTS; i++) begin : g_cell
		ptt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.clear   (clear_all),
			.tok_in  (tok_chain[i]),
			.tok_out (tok_chain[i+1]),
			.fire    (fires[i])
		);
	end

	// at most one cell reports a firing per cycle
	always_comb begin
		fire_any = 1'b0;
		fire_idx = '0;
		for (int i = 0; i < ptt_pkg::NUM_SLOTS; i++) begin
			fire_any = fire_any | fires[i].fire;
			fire_idx = fire_idx | (fires[i].fire ? fires[i].idx : '0);
		end
	end

	// result sequencing: each firing is held pending so the last is known
	always_comb begin
		busy_d       = busy_q;
		pend_valid_d = pend_valid_q;
		pend_idx_d   = pend_idx_q;
		strobe_d     = 1'b0;
		result_d     = '0;
		if (accept && (cmd.kind != ptt_pkg::KIND_CLEAR))
			busy_d = 1'b1;
		if (fire_any) begin
			if (pend_valid_q) begin
				strobe_d            = 1'b1;
				result_d.event_res  = ptt_pkg::EV_FIRED;
				result_d.slot_index = 4'(pend_idx_q);
			end
			pend_valid_d = 1'b1;
			pend_idx_d   = fire_idx;
		end
		if (done_q.active) begin
			busy_d = 1'b0;
			unique case (done_q.kind)
				ptt_pkg::KIND_TICK: begin
					if (pend_valid_q) begin
						strobe_d             = 1'b1;
						result_d.event_res   = ptt_pkg::EV_FIRED;
						result_d.slot_index  = 4'(pend_idx_q);
						result_d.last_of_run = 1'b1;
					end
					pend_valid_d = 1'b0;
				end
				ptt_pkg::KIND_REG: begin
					strobe_d             = 1'b1;
					result_d.last_of_run = 1'b1;
					if (done_q.found) begin
						result_d.event_res  = ptt_pkg::EV_REGISTERED;
						result_d.slot_index = 4'(done_q.found_idx);
					end else begin
						result_d.event_res  = ptt_pkg::EV_REJECTED;
						result_d.slot_index = '0;
					end
				end
				ptt_pkg::KIND_UNREG: begin
					strobe_d             = 1'b1;
					result_d.last_of_run = 1'b1;
					result_d.slot_index  = done_q.slot;
					result_d.event_res   = done_q.found ? ptt_pkg::EV_UNREGISTERED
					                                    : ptt_pkg::EV_UNREG_EMPTY;
				end
				ptt_pkg::KIND_CLEAR: begin
				end
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s0       <= '0;
			done_q       <= '0;
			busy_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			tok_s0       <= launch_d;
			done_q       <= tok_chain[ptt_pkg::NUM_SLOTS];
			busy_q       <= busy_d;
			pend_valid_q <= pend_valid_d;
			strobe_q     <= strobe_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		pend_idx_q <= pend_idx_d;
		result_q   <= result_d;
	end

	assign busy   = busy_q;
	assign strobe = strobe_q;
	assign result = result_q;

endmodule

`default_nettype wire
